### hw/rtl/linear_interpolation_upsampler_unit_macros.svh
// assertion macros for the linear interpolation upsampler
`ifndef LINEAR_INTERPOLATION_UPSAMPLER_UNIT_MACROS_SVH
`define LINEAR_INTERPOLATION_UPSAMPLER_UNIT_MACROS_SVH

// condition must hold in the same cycle
`define LIU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition must hold in the next cycle
`define LIU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/liu_pkg.sv
// types and constants of the linear interpolation upsampler
`default_nettype none
package liu_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 6;
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_sample;
  } liu_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_value;
    logic                       run_last;
    logic                       stream_end;
  } liu_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_INTERP,
    ST_TAIL
  } liu_state_t;

endpackage
`default_nettype wire

### hw/rtl/linear_interpolation_upsampler_unit.sv
// linear interpolation upsampler: restoring divider plus incremental step sequencer
// the first result is registered after the ST_DIV and ST_SETUP states; a first sample
// marked last goes straight to ST_TAIL; further results one per cycle while out_stall is low
// in_stall stays high until the block is back in ST_IDLE, so no new sample is taken before
// all results of the last one are registered; a first sample that is not last is only stored
// reset (synchronous, rst_n low): factor 2, no previous sample, minimum 0, output empty
`default_nettype none
`include "linear_interpolation_upsampler_unit_macros.svh"
module linear_interpolation_upsampler_unit
  import liu_pkg::*;
#(
  parameter int MAX_FACTOR = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire liu_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output liu_out_t              out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  // widths: FW holds factor, DW holds a sample difference, CW counts both loops
  localparam int FW  = $clog2(MAX_FACTOR + 1);
  localparam int DW  = SAMPLE_W + 1;
  localparam int DCW = $clog2(DW);
  localparam int CW  = (DCW > FW) ? DCW : FW;

  // control state
  liu_state_t state_r, state_nxt;
  logic [CFG_W-1:0] cfg_r;
  logic             have_r, have_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  // stream state
  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;

  // per-item working registers
  logic signed [SAMPLE_W-1:0] cur_r, cur_nxt;
  logic                       last_r, last_nxt;
  logic [FW-1:0]              f_r, f_nxt;
  logic                       neg_r, neg_nxt;
  logic [DW-1:0]              quo_r, quo_nxt;   // dividend in, quotient out
  logic [FW-1:0]              rem_r, rem_nxt;
  logic signed [DW-1:0]       qd_r, qd_nxt;     // floor(diff / f)
  logic [FW-1:0]              rd_r, rd_nxt;     // matching remainder
  logic signed [DW-1:0]       qacc_r, qacc_nxt; // floor(j * diff / f)
  logic [FW-1:0]              racc_r, racc_nxt;
  liu_out_t                   out_r, out_nxt;

  // combinational helpers
  logic                 accept;
  logic                 out_free;
  logic [FW-1:0]        f_clamped;
  logic signed [DW-1:0] cur_ext, prev_ext;
  logic signed [DW-1:0] diff_up, diff_dn;
  logic [FW:0]          shifted;
  logic                 div_ge;
  logic [FW:0]          rsum;
  logic                 racc_ge;
  logic signed [DW-1:0] interp_sum;
  logic                 f_end;
  logic                 div_end;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  // output register can be loaded when empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;

  // factor zero acts as one, large factors saturate
  always_comb begin
    if (cfg_r == '0) begin
      f_clamped = FW'(1);
    end else if (cfg_r > CFG_W'(MAX_FACTOR)) begin
      f_clamped = FW'(MAX_FACTOR);
    end else begin
      f_clamped = FW'(cfg_r);
    end
  end

  // difference in both directions, magnitude chosen by sign (one adder depth)
  assign cur_ext  = {in_data.sample_value[SAMPLE_W-1], in_data.sample_value};
  assign prev_ext = {prev_r[SAMPLE_W-1], prev_r};
  assign diff_up  = cur_ext - prev_ext;
  assign diff_dn  = prev_ext - cur_ext;

  // one restoring division step: bring in the next dividend bit, trial subtract
  assign shifted = {rem_r, quo_r[DW-1]};
  assign div_ge  = (shifted >= {1'b0, f_r});

  // incremental step: remainder carries into quotient when it reaches f
  assign rsum    = {1'b0, racc_r} + {1'b0, rd_r};
  assign racc_ge = (rsum >= {1'b0, f_r});

  assign interp_sum = prev_ext + qacc_r;
  assign f_end      = (cnt_r == CW'(f_r - FW'(1)));
  assign div_end    = (cnt_r == CW'(DW - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (have_r) begin
            state_nxt = ST_DIV;
          end else if (in_data.last_sample) begin
            state_nxt = ST_TAIL;
          end
        end
      end
      ST_DIV: begin
        if (div_end) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_INTERP;
      end
      ST_INTERP: begin
        if (out_free && f_end) begin
          state_nxt = last_r ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (out_free && f_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    have_nxt      = have_r;
    prev_nxt      = prev_r;
    min_nxt       = min_r;
    cur_nxt       = cur_r;
    last_nxt      = last_r;
    f_nxt         = f_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    qd_nxt        = qd_r;
    rd_nxt        = rd_r;
    qacc_nxt      = qacc_r;
    racc_nxt      = racc_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cur_nxt  = in_data.sample_value;
          last_nxt = in_data.last_sample;
          f_nxt    = f_clamped;
          neg_nxt  = diff_up[DW-1];
          quo_nxt  = diff_up[DW-1] ? diff_dn : diff_up;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          if (in_data.sample_value <= min_r) begin
            min_nxt = in_data.sample_value;
          end
          // first sample of a stream that is not last is only stored
          if (!have_r && !in_data.last_sample) begin
            prev_nxt = in_data.sample_value;
            have_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? FW'(shifted - {1'b0, f_r}) : FW'(shifted);
        quo_nxt = {quo_r[DW-2:0], div_ge};
        cnt_nxt = div_end ? '0 : cnt_r + CW'(1);
      end
      ST_SETUP: begin
        // turn |diff| / f into floor division of the signed difference
        if (!neg_r) begin
          qd_nxt = quo_r;
          rd_nxt = rem_r;
        end else if (rem_r == '0) begin
          qd_nxt = DW'(0) - quo_r;
          rd_nxt = '0;
        end else begin
          qd_nxt = ~quo_r;
          rd_nxt = f_r - rem_r;
        end
        qacc_nxt = '0;
        racc_nxt = '0;
        cnt_nxt  = '0;
      end
      ST_INTERP: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.out_value  = interp_sum[SAMPLE_W-1:0];
          out_nxt.run_last   = f_end && !last_r;
          out_nxt.stream_end = 1'b0;
          if (racc_ge) begin
            racc_nxt = FW'(rsum - {1'b0, f_r});
            qacc_nxt = qacc_r + qd_r + DW'(1);
          end else begin
            racc_nxt = rsum[FW-1:0];
            qacc_nxt = qacc_r + qd_r;
          end
          if (f_end) begin
            cnt_nxt = '0;
            if (!last_r) begin
              prev_nxt = cur_r;
              have_nxt = 1'b1;
            end
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.out_value  = (cnt_r == '0) ? cur_r : min_r;
          out_nxt.run_last   = f_end;
          out_nxt.stream_end = f_end;
          if (f_end) begin
            // stream finished, clear for the next one
            cnt_nxt  = '0;
            prev_nxt = '0;
            have_nxt = 1'b0;
            min_nxt  = '0;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= CFG_RESET;
      have_r      <= 1'b0;
      prev_r      <= '0;
      min_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      have_r      <= have_nxt;
      prev_r      <= prev_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    last_r <= last_nxt;
    f_r    <= f_nxt;
    neg_r  <= neg_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    qd_r   <= qd_nxt;
    rd_r   <= rd_nxt;
    qacc_r <= qacc_nxt;
    racc_r <= racc_nxt;
    out_r  <= out_nxt;
  end

  // running minimum starts at zero each stream and only moves down within it
  `LIU_ASSERT_SAME(a_min_nonpos, clk, rst_n, !min_r[SAMPLE_W-1], min_r == '0, "running minimum above zero")
  // step remainder stays below the factor while interpolating
  `LIU_ASSERT_SAME(a_racc_range, clk, rst_n, state_r == ST_INTERP, racc_r < f_r, "step remainder out of range")
  // the end of a stream is always the end of its sample's results
  `LIU_ASSERT_SAME(a_end_is_last, clk, rst_n, out_valid_r && out_r.stream_end, out_r.run_last, "stream end without run last")
  // an accepted sample with a stored predecessor always enters the divider
  `LIU_ASSERT_NEXT(a_div_entry, clk, rst_n, accept && have_r, state_r == ST_DIV, "divider not started")

endmodule
`default_nettype wire
